FILE: sv/rsi_pkg.sv
// Shared types and constants for the ray/sphere intersection pipeline.
// Holds the transfer payload structs, the outcome codes and the pipeline tag.
// No dependencies.
package rsi_pkg;

	localparam int unsigned COORD_BITS  = 32;
	localparam int unsigned RADIUS_BITS = 31;
	localparam int unsigned DIST_BITS   = 31;

	typedef enum logic [1:0] {
		OUTCOME_MISS    = 2'd0,
		OUTCOME_FRONT   = 2'd1,
		OUTCOME_TANGENT = 2'd2,
		OUTCOME_INSIDE  = 2'd3
	} outcome_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] origin_x;
		logic signed [COORD_BITS-1:0] origin_y;
		logic signed [COORD_BITS-1:0] origin_z;
		logic signed [COORD_BITS-1:0] dir_x;
		logic signed [COORD_BITS-1:0] dir_y;
		logic signed [COORD_BITS-1:0] dir_z;
		logic signed [COORD_BITS-1:0] center_x;
		logic signed [COORD_BITS-1:0] center_y;
		logic signed [COORD_BITS-1:0] center_z;
		logic [RADIUS_BITS-1:0]       radius;
	} query_t;

	typedef struct packed {
		logic                 hit;
		logic [1:0]           outcome;
		logic [DIST_BITS-1:0] distance;
	} answer_t;

	// Valid bit and classification that travel with an item down the pipeline.
	typedef struct packed {
		logic     vld;
		outcome_t outcome;
	} tag_t;

endpackage

FILE: sv/rsi_root_div.sv
// Back half of the ray/sphere pipeline: integer square root of the discriminant,
// one root bit per stage, then a restoring divider, one quotient bit per stage.
// Depends on rsi_pkg.
module rsi_root_div #(
	parameter int unsigned HABS_W    = 65,
	parameter int unsigned A_W       = 64,
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  rsi_pkg::tag_t                   src_tag,
	input  logic [2*HABS_W-1:0]             rad,
	input  logic [HABS_W-1:0]               habs,
	input  logic [A_W-1:0]                  a_val,
	output rsi_pkg::tag_t                   res_tag,
	output logic [rsi_pkg::DIST_BITS-1:0]   res_dist
);

	localparam int unsigned RW   = HABS_W;
	localparam int unsigned RADW = 2 * HABS_W;
	localparam int unsigned RMW  = RW + 3;
	localparam int unsigned DQ   = rsi_pkg::DIST_BITS;
	localparam int unsigned NW   =
		((HABS_W + FRAC_BITS) > (A_W + DQ) ? (HABS_W + FRAC_BITS) : (A_W + DQ)) + 1;

	// Square root pipeline; index 0 is the input side.
	logic [RADW-1:0]   sq_rad_s  [RW+1];
	logic [RMW-1:0]    sq_rem_s  [RW+1];
	logic [RW-1:0]     sq_root_s [RW+1];
	logic [HABS_W-1:0] sq_habs_s [RW+1];
	logic [A_W-1:0]    sq_a_s    [RW+1];
	rsi_pkg::tag_t     sq_tag_s  [RW+1];

	assign sq_rad_s[0]  = rad;
	assign sq_rem_s[0]  = '0;
	assign sq_root_s[0] = '0;
	assign sq_habs_s[0] = habs;
	assign sq_a_s[0]    = a_val;
	assign sq_tag_s[0]  = src_tag;

	for (genvar i = 0; i < RW; i++) begin : g_sqrt
		logic [RMW-1:0] remx;
		logic [RMW-1:0] trial;
		logic           take;

		always_comb begin
			remx  = {sq_rem_s[i][RMW-3:0], sq_rad_s[i][RADW-1 -: 2]};
			trial = RMW'({sq_root_s[i], 2'b01});
			take  = remx >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_tag_s[i+1] <= '0;
			end else if (en) begin
				sq_tag_s[i+1] <= sq_tag_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rad_s[i+1]  <= sq_rad_s[i] << 2;
				sq_rem_s[i+1]  <= take ? remx - trial : remx;
				sq_root_s[i+1] <= {sq_root_s[i][RW-2:0], take};
				sq_habs_s[i+1] <= sq_habs_s[i];
				sq_a_s[i+1]    <= sq_a_s[i];
			end
		end
	end

	// Numerator of the near root: -h - sqrt(D), with h not positive where it is used.
	logic [HABS_W-1:0] nm_num_s;
	logic [A_W-1:0]    nm_a_s;
	rsi_pkg::tag_t     nm_tag_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nm_tag_s <= '0;
		end else if (en) begin
			nm_tag_s <= sq_tag_s[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nm_num_s <= sq_habs_s[RW] - sq_root_s[RW];
			nm_a_s   <= sq_a_s[RW];
		end
	end

	// Divider pipeline; stage 0 holds the scaled numerator and the overflow check.
	logic [NW-1:0]  dv_rem_s [DQ+1];
	logic [A_W-1:0] dv_a_s   [DQ+1];
	logic [DQ-1:0]  dv_q_s   [DQ+1];
	logic           dv_sat_s [DQ+1];
	rsi_pkg::tag_t  dv_tag_s [DQ+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_tag_s[0] <= '0;
		end else if (en) begin
			dv_tag_s[0] <= nm_tag_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem_s[0] <= NW'(nm_num_s) << FRAC_BITS;
			dv_sat_s[0] <= (NW'(nm_num_s) << FRAC_BITS) >= (NW'(nm_a_s) << DQ);
			dv_a_s[0]   <= nm_a_s;
			dv_q_s[0]   <= '0;
		end
	end

	for (genvar j = 0; j < DQ; j++) begin : g_div
		logic [NW-1:0] sub;
		logic          take;

		always_comb begin
			sub  = NW'(dv_a_s[j]) << (DQ - 1 - j);
			take = dv_rem_s[j] >= sub;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_tag_s[j+1] <= '0;
			end else if (en) begin
				dv_tag_s[j+1] <= dv_tag_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[j+1] <= take ? dv_rem_s[j] - sub : dv_rem_s[j];
				dv_q_s[j+1]   <= dv_q_s[j] | (DQ'(take) << (DQ - 1 - j));
				dv_sat_s[j+1] <= dv_sat_s[j];
				dv_a_s[j+1]   <= dv_a_s[j];
			end
		end
	end

	assign res_tag = dv_tag_s[DQ];

	always_comb begin
		if (dv_tag_s[DQ].outcome == rsi_pkg::OUTCOME_FRONT
				|| dv_tag_s[DQ].outcome == rsi_pkg::OUTCOME_TANGENT) begin
			res_dist = dv_sat_s[DQ] ? '1 : dv_q_s[DQ];
		end else begin
			res_dist = '0;
		end
	end

endmodule

FILE: sv/ray_sphere_intersect.sv
// Top level of the ray/sphere intersection pipeline: quadratic set-up,
// discriminant, classification and output skid buffer.
// Depends on rsi_pkg and rsi_root_div.
//
//   channel   valid          stall          payload
//   query     query_valid    query_stall    query  (rsi_pkg::query_t)
//   answer    answer_valid   answer_stall   answer (rsi_pkg::answer_t)
//
// One transfer per cycle is sustained on both channels while answer_stall stays low.
// The square root resolves one root bit per stage and the divider one quotient bit per stage.
// Reset clears every valid bit and the output buffer; payload registers are not reset.
// The pipeline advances as one; a two-entry output buffer absorbs one extra result,
// so query_stall is a register and never depends on answer_stall in the same cycle.
module ray_sphere_intersect #(
	parameter int unsigned COORD_WIDTH = 32,
	parameter int unsigned FRAC_BITS   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              query_valid,
	output logic              query_stall,
	input  rsi_pkg::query_t   query,
	output logic              answer_valid,
	input  logic              answer_stall,
	output rsi_pkg::answer_t  answer
);

	localparam int unsigned W    = COORD_WIDTH;
	localparam int unsigned RRW  = 2 * rsi_pkg::RADIUS_BITS;
	// Unsigned width that holds |c| for any coordinate width.
	localparam int unsigned MOP  = (2 * W + 2 > RRW) ? 2 * W + 2 : RRW;
	localparam int unsigned AW   = 2 * W;
	localparam int unsigned HW   = 2 * W + 2;
	localparam int unsigned HAW  = 2 * W + 1;
	localparam int unsigned CW   = MOP + 1;
	localparam int unsigned HK   = W + 1;
	localparam int unsigned CK   = (MOP + 1) / 2;
	localparam int unsigned HSW  = 2 * HAW;
	localparam int unsigned ACW  = AW + MOP;
	localparam int unsigned DW   = (HSW > ACW ? HSW : ACW) + 2;

	// The whole pipeline moves together; it only halts while the skid entry is full.
	logic en;
	logic skid_v_q;
	logic out_v_q;

	assign en          = !skid_v_q;
	assign query_stall = skid_v_q;

	// Stage 1: extend the coordinates to the working width and form l = origin - center.
	logic signed [W-1:0] org [3];
	logic signed [W-1:0] dir [3];
	logic signed [W-1:0] ctr [3];

	assign org[0] = W'(query.origin_x);
	assign org[1] = W'(query.origin_y);
	assign org[2] = W'(query.origin_z);
	assign dir[0] = W'(query.dir_x);
	assign dir[1] = W'(query.dir_y);
	assign dir[2] = W'(query.dir_z);
	assign ctr[0] = W'(query.center_x);
	assign ctr[1] = W'(query.center_y);
	assign ctr[2] = W'(query.center_z);

	logic                             vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [W-1:0]              d_s1 [3];
	logic signed [W:0]                l_s1 [3];
	logic [rsi_pkg::RADIUS_BITS-1:0]  r_s1;

	// Stage 2: the ten component products.
	logic signed [2*W-1:0]            dd_s2 [3];
	logic signed [2*W:0]              dl_s2 [3];
	logic signed [2*W+1:0]            ll_s2 [3];
	logic [RRW-1:0]                   rr_s2;

	for (genvar k = 0; k < 3; k++) begin : g_axis
		logic signed [W:0] o_ext;
		logic signed [W:0] c_ext;

		assign o_ext = org[k];
		assign c_ext = ctr[k];

		always_ff @(posedge clk) begin
			if (en) begin
				d_s1[k]  <= dir[k];
				l_s1[k]  <= o_ext - c_ext;
				dd_s2[k] <= d_s1[k] * d_s1[k];
				dl_s2[k] <= d_s1[k] * l_s1[k];
				ll_s2[k] <= l_s1[k] * l_s1[k];
			end
		end
	end

	// Stage 3: a = d.d, h = d.l, c = l.l - r*r.
	logic signed [AW+1:0]   a_full;
	logic signed [RRW:0]    rr_signed;
	logic [AW-1:0]          a_s3;
	logic signed [HW-1:0]   h_s3;
	logic signed [CW-1:0]   c_s3;

	assign a_full    = dd_s2[0] + dd_s2[1] + dd_s2[2];
	assign rr_signed = $signed({1'b0, rr_s2});

	// Stage 4: magnitudes and sign flags.
	logic [HAW-1:0]  habs_s4;
	logic [MOP-1:0]  cabs_s4;
	logic [AW-1:0]   a_s4;
	logic            hpos_s4, cneg_s4, czero_s4, azero_s4;

	// Stage 5: partial products of h*h and a*|c|.
	logic [2*HK-1:0]   hll_s5;
	logic [HK+W-1:0]   hlh_s5;
	logic [2*W-1:0]    hhh_s5;
	logic [W+CK-1:0]   all_s5;
	logic [MOP-1:0]    alh_s5;
	logic [W+CK-1:0]   ahl_s5;
	logic [MOP-1:0]    ahh_s5;
	logic [HAW-1:0]    habs_s5;
	logic [AW-1:0]     a_s5;
	logic              hpos_s5, cneg_s5, czero_s5, azero_s5;

	// Stage 6: h*h and a*|c| assembled.
	logic [HSW-1:0]    hsq_s6;
	logic [ACW-1:0]    ac_s6;
	logic [HAW-1:0]    habs_s6;
	logic [AW-1:0]     a_s6;
	logic              hpos_s6, cneg_s6, czero_s6, azero_s6;

	// Stage 7: discriminant D = h*h - a*c.
	logic signed [DW-1:0] disc_s7;
	logic [HAW-1:0]       habs_s7;
	logic [AW-1:0]        a_s7;
	logic                 hpos_s7, cneg_s7, czero_s7, azero_s7;

	// Stage 8: classified item handed to the root and divide pipeline.
	rsi_pkg::tag_t   tag_s8;
	logic [HSW-1:0]  rad_s8;
	logic [HAW-1:0]  habs_s8;
	logic [AW-1:0]   a_s8;

	rsi_pkg::outcome_t outcome_c;

	always_comb begin
		priority if (azero_s7 || disc_s7[DW-1]) begin
			outcome_c = rsi_pkg::OUTCOME_MISS;
		end else if (disc_s7 == '0) begin
			outcome_c = hpos_s7 ? rsi_pkg::OUTCOME_MISS : rsi_pkg::OUTCOME_TANGENT;
		end else if (!hpos_s7 && !cneg_s7) begin
			outcome_c = rsi_pkg::OUTCOME_FRONT;
		end else if (hpos_s7 && !cneg_s7 && !czero_s7) begin
			// Both roots lie behind the origin.
			outcome_c = rsi_pkg::OUTCOME_MISS;
		end else begin
			outcome_c = rsi_pkg::OUTCOME_INSIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			tag_s8 <= '0;
		end else if (en) begin
			vld_s1 <= query_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			tag_s8 <= '{vld: vld_s7, outcome: outcome_c};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1  <= query.radius;
			rr_s2 <= r_s1 * r_s1;

			a_s3 <= a_full[AW-1:0];
			h_s3 <= dl_s2[0] + dl_s2[1] + dl_s2[2];
			c_s3 <= ll_s2[0] + ll_s2[1] + ll_s2[2] - rr_signed;

			habs_s4  <= h_s3[HW-1] ? HAW'(-h_s3) : HAW'(h_s3);
			cabs_s4  <= c_s3[CW-1] ? MOP'(-c_s3) : MOP'(c_s3);
			a_s4     <= a_s3;
			hpos_s4  <= !h_s3[HW-1] && (h_s3 != '0);
			cneg_s4  <= c_s3[CW-1];
			czero_s4 <= c_s3 == '0;
			azero_s4 <= a_s3 == '0;

			hll_s5   <= habs_s4[HK-1:0] * habs_s4[HK-1:0];
			hlh_s5   <= habs_s4[HK-1:0] * habs_s4[HAW-1:HK];
			hhh_s5   <= habs_s4[HAW-1:HK] * habs_s4[HAW-1:HK];
			all_s5   <= a_s4[W-1:0] * cabs_s4[CK-1:0];
			alh_s5   <= a_s4[W-1:0] * cabs_s4[MOP-1:CK];
			ahl_s5   <= a_s4[AW-1:W] * cabs_s4[CK-1:0];
			ahh_s5   <= a_s4[AW-1:W] * cabs_s4[MOP-1:CK];
			habs_s5  <= habs_s4;
			a_s5     <= a_s4;
			hpos_s5  <= hpos_s4;
			cneg_s5  <= cneg_s4;
			czero_s5 <= czero_s4;
			azero_s5 <= azero_s4;

			// The cross term of the square appears twice, hence the extra shift.
			hsq_s6   <= (HSW'(hhh_s5) << (2 * HK)) + (HSW'(hlh_s5) << (HK + 1))
				+ HSW'(hll_s5);
			ac_s6    <= (ACW'(ahh_s5) << (W + CK)) + (ACW'(alh_s5) << CK)
				+ (ACW'(ahl_s5) << W) + ACW'(all_s5);
			habs_s6  <= habs_s5;
			a_s6     <= a_s5;
			hpos_s6  <= hpos_s5;
			cneg_s6  <= cneg_s5;
			czero_s6 <= czero_s5;
			azero_s6 <= azero_s5;

			disc_s7  <= cneg_s6 ? DW'(hsq_s6) + DW'(ac_s6) : DW'(hsq_s6) - DW'(ac_s6);
			habs_s7  <= habs_s6;
			a_s7     <= a_s6;
			hpos_s7  <= hpos_s6;
			cneg_s7  <= cneg_s6;
			czero_s7 <= czero_s6;
			azero_s7 <= azero_s6;

			// Only a front entry needs the root; there D never exceeds h*h.
			rad_s8  <= (outcome_c == rsi_pkg::OUTCOME_FRONT) ? disc_s7[HSW-1:0] : '0;
			habs_s8 <= habs_s7;
			a_s8    <= a_s7;
		end
	end

	rsi_pkg::tag_t                  res_tag;
	logic [rsi_pkg::DIST_BITS-1:0]  res_dist;

	rsi_root_div #(
		.HABS_W    (HAW),
		.A_W       (AW),
		.FRAC_BITS (FRAC_BITS)
	) u_root_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.src_tag  (tag_s8),
		.rad      (rad_s8),
		.habs     (habs_s8),
		.a_val    (a_s8),
		.res_tag  (res_tag),
		.res_dist (res_dist)
	);

	// Output register plus one skid entry.
	rsi_pkg::answer_t arr_data;
	rsi_pkg::answer_t out_q;
	rsi_pkg::answer_t skid_q;

	assign arr_data = '{
		hit:      res_tag.outcome != rsi_pkg::OUTCOME_MISS,
		outcome:  res_tag.outcome,
		distance: res_dist
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || !answer_stall) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= res_tag.vld;
			end
		end else if (res_tag.vld && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || !answer_stall) begin
			out_q <= skid_v_q ? skid_q : arr_data;
		end else if (!skid_v_q) begin
			skid_q <= arr_data;
		end
	end

	assign answer_valid = out_v_q;
	assign answer       = out_q;

	// The skid entry only fills while a result sits stalled at the output.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && answer_stall))
		else $error("skid entry filled without a stalled output");

	// A full skid entry implies a result on the output.
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry holds data while the output is empty");

	// Once the output drains, the input side opens on the next cycle.
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		query_stall && !answer_stall |=> !query_stall)
		else $error("query stall held after the output drained");

	// Misses and inside hits carry no distance.
	a_dist_zero: assert property (@(posedge clk) disable iff (!arst_n)
		answer_valid && (answer.outcome == rsi_pkg::OUTCOME_MISS
			|| answer.outcome == rsi_pkg::OUTCOME_INSIDE) |-> answer.distance == '0)
		else $error("distance reported on a miss or inside hit");

endmodule
